/* hw/rtl/vn_pkg.sv */
// vn_pkg: shared constants and the control type for the vector3_normalize block
// no dependencies; used by vector3_normalize and vn_sqrt

package vn_pkg;

    localparam int FIELD_BITS             = 32;
    localparam int COMPONENT_BITS_DEF     = 32;
    localparam int UNIT_FRACTION_BITS_DEF = 30;
    localparam int LANES                  = 3;

    // control that travels beside the data through every stage
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

/* hw/rtl/vector3_normalize.sv */
// Normalizes one 3D vector per item: length = floor(sqrt(x*x+y*y+z*z)) in the input's
// fixed-point format, and each component divided by that length with UNIT_FRACTION_BITS
// fraction bits, truncated toward zero; a zero vector returns zeros with the flag set.
// A new item is taken every cycle unless the pipeline holds. The stages are the two input
// stages, the one-bit-per-stage square root, the three one-bit-per-stage divider lanes and
// the output register. The whole pipeline holds while a result waits unread.
// Depends on vn_pkg, vn_sqrt and vn_div.

module vector3_normalize #(
    parameter int COMPONENT_BITS     = vn_pkg::COMPONENT_BITS_DEF,
    parameter int UNIT_FRACTION_BITS = vn_pkg::UNIT_FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // comp_x, comp_y, comp_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // magnitude, unit_x, unit_y, unit_z
    output logic         m_axis_tuser    // zero_vector
);

    localparam int CB = COMPONENT_BITS;
    localparam int UF = UNIT_FRACTION_BITS;
    localparam int FB = vn_pkg::FIELD_BITS;
    localparam int NL = vn_pkg::LANES;
    localparam int SB = NL * CB + NL;

    logic w_en;

    // stage 1: magnitudes and signs
    logic [CB-1:0]  n_abs  [0:NL-1];
    logic           n_neg  [0:NL-1];
    logic [CB-1:0]  r_abs1 [0:NL-1];
    logic           r_neg1 [0:NL-1];
    vn_pkg::t_ctl   r_ctl1;

    // stage 2: squares
    logic [2*CB-1:0] r_sq2  [0:NL-1];
    logic [CB-1:0]   r_abs2 [0:NL-1];
    logic [NL-1:0]   r_neg2;
    vn_pkg::t_ctl    r_ctl2;

    logic [2*CB-1:0] w_rad;
    logic [SB-1:0]   w_sb_in;
    vn_pkg::t_ctl    w_sq_ctl;
    logic [CB-1:0]   w_len;
    logic [SB-1:0]   w_sb_out;

    logic [UF:0]     w_quo [0:NL-1];

    vn_pkg::t_ctl    r_dctl [0:UF];
    logic [NL-1:0]   r_dneg [0:UF];
    logic [CB-1:0]   r_dlen [0:UF];

    logic            r_out_vld;
    logic            r_out_zero;
    logic [FB-1:0]   r_out_mag;
    logic [FB-1:0]   r_out_unit [0:NL-1];
    logic [FB-1:0]   n_mag;
    logic [FB-1:0]   n_unit [0:NL-1];

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    for (genvar j = 0; j < NL; j++) begin : g_abs
        logic [CB-1:0] n_raw;
        if (CB <= FB) begin : g_narrow
            assign n_raw = s_axis_tdata[j*FB +: CB];
        end else begin : g_wide
            assign n_raw = {{(CB-FB){1'b0}}, s_axis_tdata[j*FB +: FB]};
        end
        assign n_neg[j] = n_raw[CB-1];
        assign n_abs[j] = n_raw[CB-1] ? (~n_raw + 1'b1) : n_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (w_en) begin
            r_ctl1.valid <= s_axis_tvalid;
            r_ctl1.zero  <= (n_abs[0] == '0) && (n_abs[1] == '0) && (n_abs[2] == '0);
            r_ctl2       <= r_ctl1;
        end
        if (w_en) begin
            for (int j = 0; j < NL; j++) begin
                r_abs1[j] <= n_abs[j];
                r_neg1[j] <= n_neg[j];
                r_sq2[j]  <= r_abs1[j] * r_abs1[j];
                r_abs2[j] <= r_abs1[j];
                r_neg2[j] <= r_neg1[j];
            end
        end
    end

    // sum of three squares stays below 2^(2*CB)
    assign w_rad   = r_sq2[0] + r_sq2[1] + r_sq2[2];
    assign w_sb_in = {r_neg2, r_abs2[2], r_abs2[1], r_abs2[0]};

    vn_sqrt #(
        .CB (CB),
        .SB (SB)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_ctl2),
        .i_rad   (w_rad),
        .i_sb    (w_sb_in),
        .o_ctl   (w_sq_ctl),
        .o_root  (w_len),
        .o_sb    (w_sb_out)
    );

    for (genvar j = 0; j < NL; j++) begin : g_lane
        vn_div #(
            .CB (CB),
            .UF (UF)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_sb_out[j*CB +: CB]),
            .i_den (w_len),
            .o_quo (w_quo[j])
        );
    end

    // control, signs and length ride beside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= UF; k++) begin
                r_dctl[k] <= '0;
            end
        end else if (w_en) begin
            r_dctl[0] <= w_sq_ctl;
            for (int k = 1; k <= UF; k++) begin
                r_dctl[k] <= r_dctl[k-1];
            end
        end
        if (w_en) begin
            r_dneg[0] <= w_sb_out[NL*CB +: NL];
            r_dlen[0] <= w_len;
            for (int k = 1; k <= UF; k++) begin
                r_dneg[k] <= r_dneg[k-1];
                r_dlen[k] <= r_dlen[k-1];
            end
        end
    end

    // merge: saturate the length, apply signs, force zeros for a zero vector
    if (CB > FB) begin : g_sat
        assign n_mag = (r_dlen[UF][CB-1:FB] != '0) ? '1 : r_dlen[UF][FB-1:0];
    end else begin : g_nosat
        assign n_mag = FB'(r_dlen[UF]);
    end

    for (genvar j = 0; j < NL; j++) begin : g_merge
        logic [FB-1:0] n_q;
        assign n_q       = FB'(w_quo[j]);
        assign n_unit[j] = r_dctl[UF].zero ? '0 : (r_dneg[UF][j] ? (~n_q + 1'b1) : n_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dctl[UF].valid;
        end
        if (w_en) begin
            r_out_zero <= r_dctl[UF].zero;
            r_out_mag  <= r_dctl[UF].zero ? '0 : n_mag;
            for (int j = 0; j < NL; j++) begin
                r_out_unit[j] <= n_unit[j];
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_unit[2], r_out_unit[1], r_out_unit[0], r_out_mag};
    assign m_axis_tuser  = r_out_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero vector result carries nonzero data");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[FB-1:0] != '0))
        else $error("nonzero vector gave zero length");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is stalled");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dctl[UF].valid && !r_dctl[UF].zero) |-> (w_quo[0] <= (1 << UF)))
        else $error("unit component above one");

endmodule

/* hw/rtl/vn_sqrt.sv */
// vn_sqrt: pipelined integer square root, one root bit per stage
// depends on vn_pkg (t_ctl); carries a sideband bus at the same latency

module vn_sqrt #(
    parameter int CB = vn_pkg::COMPONENT_BITS_DEF,
    parameter int SB = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vn_pkg::t_ctl      i_ctl,
    input  logic [2*CB-1:0]   i_rad,
    input  logic [SB-1:0]     i_sb,
    output vn_pkg::t_ctl      o_ctl,
    output logic [CB-1:0]     o_root,
    output logic [SB-1:0]     o_sb
);

    vn_pkg::t_ctl      w_ctl  [0:CB];
    logic [2*CB-1:0]   w_rad  [0:CB];
    logic [CB+1:0]     w_rem  [0:CB];
    logic [CB-1:0]     w_root [0:CB];
    logic [SB-1:0]     w_sb   [0:CB];

    assign w_ctl[0]  = i_ctl;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_sb[0]   = i_sb;

    for (genvar s = 0; s < CB; s++) begin : g_stage
        logic [CB+1:0]   n_rem2;
        logic [CB+1:0]   n_trial;
        logic            n_ge;
        vn_pkg::t_ctl    r_ctl;
        logic [2*CB-1:0] r_rad;
        logic [CB+1:0]   r_rem;
        logic [CB-1:0]   r_root;
        logic [SB-1:0]   r_sb;

        // bring down the next two radicand bits and try root*4+1
        assign n_rem2  = {w_rem[s][CB-1:0], w_rad[s][2*CB-1 -: 2]};
        assign n_trial = {w_root[s], 2'b01};
        assign n_ge    = (n_rem2 >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[s];
            end
            if (i_en) begin
                r_rad  <= {w_rad[s][2*CB-3:0], 2'b00};
                r_rem  <= n_ge ? (n_rem2 - n_trial) : n_rem2;
                r_root <= {w_root[s][CB-2:0], n_ge};
                r_sb   <= w_sb[s];
            end
        end

        assign w_ctl[s+1]  = r_ctl;
        assign w_rad[s+1]  = r_rad;
        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_sb[s+1]   = r_sb;
    end

    assign o_ctl  = w_ctl[CB];
    assign o_root = w_root[CB];
    assign o_sb   = w_sb[CB];

endmodule

/* hw/rtl/vn_div.sv */
// vn_div: one lane of the pipelined restoring divider, floor((num << UF) / den)
// no package dependency; num must not exceed den, so the quotient has UF+1 bits

module vn_div #(
    parameter int CB = 32,
    parameter int UF = 30
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [CB-1:0] i_num,
    input  logic [CB-1:0] i_den,
    output logic [UF:0]   o_quo
);

    logic [CB:0]   w_r [0:UF+1];
    logic [CB-1:0] w_d [0:UF+1];
    logic [UF:0]   w_q [0:UF+1];

    assign w_r[0] = {1'b0, i_num};
    assign w_d[0] = i_den;
    assign w_q[0] = '0;

    for (genvar k = 0; k <= UF; k++) begin : g_stage
        logic          n_ge;
        logic [CB:0]   n_diff;
        logic [CB:0]   r_r;
        logic [CB-1:0] r_d;
        logic [UF:0]   r_q;

        assign n_ge   = (w_r[k] >= {1'b0, w_d[k]});
        assign n_diff = w_r[k] - {1'b0, w_d[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // remainder stays below den, so one shifted bit is enough
                r_r <= n_ge ? {n_diff[CB-1:0], 1'b0} : {w_r[k][CB-1:0], 1'b0};
                r_d <= w_d[k];
                r_q <= {w_q[k][UF-1:0], n_ge};
            end
        end

        assign w_r[k+1] = r_r;
        assign w_d[k+1] = r_d;
        assign w_q[k+1] = r_q;
    end

    assign o_quo = w_q[UF+1];

endmodule

/* verif/vector3_normalize_tb.sv */
// vector3_normalize_tb: self-checking bench for the vector normalizer, directed table then random
// vectors, each result checked field by field against typed-in values or a bit-exact predictor
// depends on vn_pkg and vector3_normalize

module vector3_normalize_tb;

    localparam int CB          = vn_pkg::COMPONENT_BITS_DEF;
    localparam int UFB         = vn_pkg::UNIT_FRACTION_BITS_DEF;
    localparam int LATENCY     = CB + UFB + 4;
    localparam int N_RANDOM    = 1250;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] cz;
        logic [31:0] cy;
        logic [31:0] cx;
    } t_vec;

    typedef struct {
        logic [31:0] magnitude;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic        zero;
    } t_norm;

    typedef struct {
        t_vec  v;
        logic  known;   // expected result typed in below
        t_norm res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;     // comp_x, comp_y, comp_z
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;          // magnitude, unit_x, unit_y, unit_z
    logic         m_axis_tuser;          // zero_vector

    t_norm expected_norms[$];
    int    n_errors = 0;
    int    idle_cycles = 0;
    bit    sending_done = 1'b0;
    bit    drain_hold = 1'b0;
    int    rx_count = 0;

    vector3_normalize i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] abs_comp(input logic [31:0] c);
        return c[31] ? -c : c;
    endfunction

    // floor(sqrt(s)), s up to 68 bits
    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  cand;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= s) r = cand;
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_comp(input logic [31:0] c, input logic [63:0] len);
        logic [95:0] q;
        q = ({64'd0, abs_comp(c)} << UFB) / {32'd0, len};
        return c[31] ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_norm normalize(input t_vec v);
        t_norm       n;
        logic [127:0] sum;
        logic [63:0]  len;
        sum = {96'd0, abs_comp(v.cx)} * {96'd0, abs_comp(v.cx)}
            + {96'd0, abs_comp(v.cy)} * {96'd0, abs_comp(v.cy)}
            + {96'd0, abs_comp(v.cz)} * {96'd0, abs_comp(v.cz)};
        if (sum == 0) begin
            n = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
            return n;
        end
        len = isqrt(sum);
        n.magnitude = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
        n.ux = unit_comp(v.cx, len);
        n.uy = unit_comp(v.cy, len);
        n.uz = unit_comp(v.cz, len);
        n.zero = 1'b0;
        return n;
    endfunction

    function automatic t_vec random_vec();
        t_vec v;
        int   shift;
        v = {$urandom, $urandom, $urandom};
        // mix full-range, short and partly zeroed vectors
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                shift = $urandom_range(0, 31);
                v.cx = $signed(v.cx) >>> shift;
                v.cy = $signed(v.cy) >>> shift;
                v.cz = $signed(v.cz) >>> shift;
            end
            2: begin
                if ($urandom_range(0, 1)) v.cx = '0;
                if ($urandom_range(0, 1)) v.cy = '0;
                if ($urandom_range(0, 1)) v.cz = '0;
            end
            default: v.cx = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, v.cx[15:0]};
        endcase
        return v;
    endfunction

    t_row directed[] = '{
        '{'{32'd0, 32'd0, 32'd0}, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1}},
        '{'{32'd0, 32'd0, 32'h0001_0000}, 1'b1,
          '{32'h0001_0000, 32'h4000_0000, 32'd0, 32'd0, 1'b0}},
        '{'{32'd0, 32'hFFFF_0000, 32'd0}, 1'b1,
          '{32'h0001_0000, 32'd0, 32'hC000_0000, 32'd0, 1'b0}},
        '{'{32'h0000_0001, 32'd0, 32'd0}, 1'b1,
          '{32'd1, 32'd0, 32'd0, 32'h4000_0000, 1'b0}},
        '{'{32'd0, 32'd0, 32'h8000_0000}, 1'b1,
          '{32'h8000_0000, 32'hC000_0000, 32'd0, 32'd0, 1'b0}},
        '{'{32'd0, 32'd0, 32'h7FFF_FFFF}, 1'b1,
          '{32'h7FFF_FFFF, 32'h4000_0000, 32'd0, 32'd0, 1'b0}},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h0000_0001, 32'h0000_0001, 32'h0000_0001}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'd0, 32'h0004_0000, 32'h0003_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE}, 1'b0, '{0, 0, 0, 0, 0}}
    };

    task automatic send_vec(input t_vec v, input t_norm exp_norm);
        // random gaps, except in the quiet stretch
        while (rx_count > 300 && rx_count < 600 ? 1'b0 : ($urandom_range(0, 99) < 24)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        expected_norms.push_back(exp_norm);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) begin
            if (directed[k].known) send_vec(directed[k].v, directed[k].res);
            else send_vec(directed[k].v, normalize(directed[k].v));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            t_vec v;
            v = random_vec();
            send_vec(v, normalize(v));
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off, and a quiet stretch
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rx_count == 100 && hold == 0 && !drain_hold) begin
                drain_hold = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_count > 300 && rx_count < 600) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_norm e;
            rx_count <= rx_count + 1;
            if (expected_norms.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                n_errors++;
            end else begin
                e = expected_norms.pop_front();
                if (m_axis_tdata[31:0] !== e.magnitude) begin
                    $error("magnitude expected %h actual %h", e.magnitude, m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (m_axis_tdata[63:32] !== e.ux) begin
                    $error("unit_x expected %h actual %h", e.ux, m_axis_tdata[63:32]);
                    n_errors++;
                end
                if (m_axis_tdata[95:64] !== e.uy) begin
                    $error("unit_y expected %h actual %h", e.uy, m_axis_tdata[95:64]);
                    n_errors++;
                end
                if (m_axis_tdata[127:96] !== e.uz) begin
                    $error("unit_z expected %h actual %h", e.uz, m_axis_tdata[127:96]);
                    n_errors++;
                end
                if (m_axis_tuser !== e.zero) begin
                    $error("zero_vector expected %b actual %b", e.zero, m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (sending_done && expected_norms.size() == 0 && idle_cycles > STALL_LIMIT - 1
              || sending_done && expected_norms.size() == 0
              || idle_cycles >= STALL_LIMIT);
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            if (n_errors == 0 && expected_norms.size() == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
            $finish;
        end
    end

endmodule
